// ----- design/alu8f_pkg.sv -----
package alu8f_pkg;

  typedef enum logic [1:0] {
    ACC_COMPUTE = 2'd0,
    ACC_LOAD    = 2'd1,
    ACC_READ    = 2'd2,
    ACC_SPARE   = 2'd3
  } access_t;

  typedef enum logic [3:0] {
    OP_ADD = 4'h0,
    OP_ADC = 4'h1,
    OP_SUB = 4'h2,
    OP_SBB = 4'h3,
    OP_AND = 4'h4,
    OP_OR  = 4'h5,
    OP_XOR = 4'h6,
    OP_INC = 4'h7,
    OP_DEC = 4'h8,
    OP_NOT = 4'h9,
    OP_SHL = 4'hA,
    OP_SHR = 4'hB,
    OP_CLR = 4'hE
  } opcode_t;

  // flag bit positions
  localparam int unsigned FLAG_Z = 0;
  localparam int unsigned FLAG_C = 1;
  localparam int unsigned FLAG_V = 2;

  typedef struct packed {
    logic [1:0] access;
    logic [3:0] opcode;
    logic [7:0] left_operand;
    logic [7:0] right_operand;
    logic [7:0] flags_load_value;
  } item_t;

  typedef struct packed {
    logic [7:0] result;
    logic       result_written;
    logic [7:0] flags_value;
  } res_t;

endpackage

// ----- design/alu8f_if.sv -----
interface alu8f_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] access;
  logic [3:0] opcode;
  logic [7:0] left_operand;
  logic [7:0] right_operand;
  logic [7:0] flags_load_value;

  modport source (
    output valid, access, opcode, left_operand, right_operand, flags_load_value,
    input  ready
  );
  modport sink (
    input  valid, access, opcode, left_operand, right_operand, flags_load_value,
    output ready
  );
endinterface

interface alu8f_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] result;
  logic       result_written;
  logic [7:0] flags_value;

  modport source (
    output valid, result, result_written, flags_value,
    input  ready
  );
  modport sink (
    input  valid, result, result_written, flags_value,
    output ready
  );
endinterface

// ----- design/alu8f_core.sv -----
module alu8f_core (
  input  alu8f_pkg::item_t item,
  input  logic [7:0]       flags,
  output alu8f_pkg::res_t  res
);

  logic [8:0] l9;
  logic [8:0] r9;
  logic [8:0] cin9;
  logic [8:0] sum;
  logic       cin;
  logic       defined;
  logic       ovf;
  logic [7:0] val;
  logic [7:0] f;

  assign cin  = flags[alu8f_pkg::FLAG_C];
  assign l9   = {1'b0, item.left_operand};
  assign r9   = {1'b0, item.right_operand};
  assign cin9 = {8'd0, cin};

  always_comb begin
    sum     = 9'd0;
    defined = 1'b1;
    case (alu8f_pkg::opcode_t'(item.opcode))
      alu8f_pkg::OP_ADD: sum = l9 + r9;
      alu8f_pkg::OP_ADC: sum = l9 + r9 + cin9;
      alu8f_pkg::OP_SUB: sum = l9 - r9;
      alu8f_pkg::OP_SBB: sum = l9 - r9 - cin9;
      alu8f_pkg::OP_AND: sum = l9 & r9;
      alu8f_pkg::OP_OR:  sum = l9 | r9;
      alu8f_pkg::OP_XOR: sum = l9 ^ r9;
      alu8f_pkg::OP_INC: sum = r9 + 9'd1;
      alu8f_pkg::OP_DEC: sum = r9 - 9'd1;
      alu8f_pkg::OP_NOT: sum = {1'b0, ~item.right_operand};
      alu8f_pkg::OP_SHL: sum = {item.right_operand, cin};
      alu8f_pkg::OP_SHR: sum = {item.right_operand[0], cin, item.right_operand[7:1]};
      alu8f_pkg::OP_CLR: sum = 9'd0;
      default:           defined = 1'b0;
    endcase
  end

  assign val = sum[7:0];

  // signed overflow, add and subtract only
  always_comb begin
    ovf = 1'b0;
    case (alu8f_pkg::opcode_t'(item.opcode))
      alu8f_pkg::OP_ADD, alu8f_pkg::OP_ADC:
        ovf = (item.left_operand[7] == item.right_operand[7]) &&
              (val[7] != item.left_operand[7]);
      alu8f_pkg::OP_SUB, alu8f_pkg::OP_SBB:
        ovf = (item.left_operand[7] != item.right_operand[7]) &&
              (val[7] != item.left_operand[7]);
      default: ovf = 1'b0;
    endcase
  end

  always_comb begin
    f                      = 8'd0;
    f[alu8f_pkg::FLAG_Z]   = (val == 8'd0);
    f[alu8f_pkg::FLAG_C]   = sum[8];
    f[alu8f_pkg::FLAG_V]   = ovf;
    res.result             = 8'd0;
    res.result_written     = 1'b0;
    res.flags_value        = flags;
    case (alu8f_pkg::access_t'(item.access))
      alu8f_pkg::ACC_COMPUTE: begin
        if (defined) begin
          res.result         = val;
          res.result_written = 1'b1;
          res.flags_value    = f;
        end
      end
      alu8f_pkg::ACC_LOAD: res.flags_value = item.flags_load_value;
      default:             res.flags_value = flags;
    endcase
  end

endmodule

// ----- design/alu_8bit_with_flags_unit.sv -----
// 8-bit ALU with its own flags register (Z bit 0, C bit 1, V bit 2). One item per
// cycle is taken on in_chan while the result register is not stalled. Its result
// passes the input register, then the result register, before it is shown on
// out_chan. The rate is one item a cycle, set by the flags feedback: the single
// compute stage reads the flags register and writes it back as the result register
// loads, so the next item in the input register already sees the updated carry. A
// stalled result register holds the compute stage and, through it, in_chan.ready.
module alu_8bit_with_flags_unit (
  input  logic              clk,
  input  logic              rst_n,
  alu8f_in_if.sink          in_chan,
  alu8f_out_if.source       out_chan
);

  // input register
  logic             s1_vld_r;
  logic             s1_vld_nxt;
  alu8f_pkg::item_t s1_item_r;

  // result register and flags
  logic             out_vld_r;
  logic             out_vld_nxt;
  alu8f_pkg::res_t  out_res_r;
  logic [7:0]       flags_r;

  alu8f_pkg::res_t  core_res;
  logic             advance;   // compute stage moves into the result register
  logic             in_xfer;

  alu8f_core u_core (
    .item  (s1_item_r),
    .flags (flags_r),
    .res   (core_res)
  );

  // result register free, or being emptied this cycle
  assign advance        = s1_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready  = !s1_vld_r || advance;
  assign in_xfer        = in_chan.valid && in_chan.ready;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_xfer) begin
      s1_vld_nxt = 1'b1;
    end else if (advance) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (advance) begin
      out_vld_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      flags_r   <= 8'd0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (advance) begin
        flags_r <= core_res.flags_value;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r.access           <= in_chan.access;
      s1_item_r.opcode           <= in_chan.opcode;
      s1_item_r.left_operand     <= in_chan.left_operand;
      s1_item_r.right_operand    <= in_chan.right_operand;
      s1_item_r.flags_load_value <= in_chan.flags_load_value;
    end
    if (advance) begin
      out_res_r <= core_res;
    end
  end

  assign out_chan.valid          = out_vld_r;
  assign out_chan.result         = out_res_r.result;
  assign out_chan.result_written = out_res_r.result_written;
  assign out_chan.flags_value    = out_res_r.flags_value;

  // flags register always matches the flags of the result on show
  a_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_res_r.flags_value == flags_r))
    else $error("flags register differs from pending result");

  // a held item in the input register keeps its payload while the output stalls
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !advance) |=> (s1_vld_r && $stable(s1_item_r)))
    else $error("input register changed while stalled");

  // an item with no written result carries a zero result byte
  a_unwritten_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_res_r.result_written) |-> (out_res_r.result == 8'd0))
    else $error("result byte non-zero on unwritten item");

  // reset empties the pipeline and clears the flags
  a_reset: assert property (@(posedge clk)
    !rst_n |=> (!out_vld_r && !s1_vld_r && flags_r == 8'd0))
    else $error("reset did not clear control state");

endmodule
